// ===== rtl/pcxrle_pkg.sv =====
// Shared types and constants for the PCX run-length line decoder.
package pcxrle_pkg;

	localparam int BYTE_W  = 8;
	localparam int CNT_W   = 6;
	localparam int COL_W   = 16;
	localparam int PLANE_W = 2;
	localparam int PLC_W   = 3;
	localparam int ROW_W   = 16;
	localparam int ROWS_W  = 17;
	localparam int DEST_W  = 18;
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;

	localparam logic [BYTE_W-1:0] RUN_TAG        = 8'hC0;
	localparam logic [BYTE_W-1:0] RUN_COUNT_MASK = 8'h3F;

	localparam logic [PLC_W-1:0]  MAX_PLANES = 3'd4;
	localparam logic [ROWS_W-1:0] MAX_ROWS   = 17'h10000;

	// register indexes (byte address / 4)
	localparam logic [1:0] REG_BPL    = 2'd0;
	localparam logic [1:0] REG_PLANES = 2'd1;
	localparam logic [1:0] REG_ROWS   = 2'd2;

	// effective (clamped) geometry
	typedef struct packed {
		logic [COL_W-1:0]  bpl;
		logic [PLC_W-1:0]  planes;
		logic [ROWS_W-1:0] rows;
	} cfg_t;

	// position unit report for the current output byte
	typedef struct packed {
		logic [DEST_W-1:0] dest;
		logic [ROW_W-1:0]  row;
		logic              line_end;
		logic              img_end;
	} pos_info_t;

endpackage

// ===== rtl/pcxrle_if.sv =====
// Valid/ready channel interfaces for the compressed input and decoded output.
interface pcxrle_in_if;
	import pcxrle_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface pcxrle_out_if;
	import pcxrle_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] pixel_byte;
	logic [DEST_W-1:0] dest_index;
	logic [ROW_W-1:0]  row_index;
	logic              run_last;
	logic              line_last;
	logic              image_last;

	modport source (output valid, output pixel_byte, output dest_index, output row_index,
		output run_last, output line_last, output image_last, input ready);
	modport sink (input valid, input pixel_byte, input dest_index, input row_index,
		input run_last, input line_last, input image_last, output ready);
endinterface

// ===== rtl/pcxrle_cfg.sv =====
// APB register bank for the line geometry, with clamped effective values.
module pcxrle_cfg
	import pcxrle_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic [COL_W-1:0]  bpl_q;
	logic [PLC_W-1:0]  planes_q;
	logic [ROWS_W-1:0] rows_q;
	logic              wr_en;
	logic [1:0]        reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpl_q    <= COL_W'(1);
			planes_q <= PLC_W'(1);
			rows_q   <= ROWS_W'(1);
		end else if (wr_en) begin
			case (reg_idx)
				REG_BPL:    bpl_q    <= pwdata[COL_W-1:0];
				REG_PLANES: planes_q <= pwdata[PLC_W-1:0];
				REG_ROWS:   rows_q   <= pwdata[ROWS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_BPL:    prdata = DATA_W'(bpl_q);
			REG_PLANES: prdata = DATA_W'(planes_q);
			REG_ROWS:   prdata = DATA_W'(rows_q);
			default:    prdata = '0;
		endcase
	end

	always_comb begin
		cfg.bpl = (bpl_q == '0) ? COL_W'(1) : bpl_q;
		if (planes_q == '0)
			cfg.planes = PLC_W'(1);
		else if (planes_q > MAX_PLANES)
			cfg.planes = MAX_PLANES;
		else
			cfg.planes = planes_q;
		if (rows_q == '0)
			cfg.rows = ROWS_W'(1);
		else if (rows_q > MAX_ROWS)
			cfg.rows = MAX_ROWS;
		else
			cfg.rows = rows_q;
	end

endmodule

// ===== rtl/pcxrle_pos.sv =====
// Shared position unit: holds column/plane/row, reports tags and steps once per output byte.
module pcxrle_pos
	import pcxrle_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      advance,
	output pos_info_t info
);

	logic [COL_W-1:0]   col_q;
	logic [PLANE_W-1:0] plane_q;
	logic [ROW_W-1:0]   row_q;
	logic               col_end;
	logic               plane_end;
	logic [DEST_W:0]    prod;

	// positions beyond a shrunken bound count as the last one
	assign col_end   = (({1'b0, col_q} + 17'd1) >= {1'b0, cfg.bpl});
	assign plane_end = (({1'b0, plane_q} + 3'd1) >= cfg.planes);
	assign prod      = (DEST_W+1)'(col_q) * (DEST_W+1)'(cfg.planes);

	always_comb begin
		info.dest     = DEST_W'(prod + (DEST_W+1)'(plane_q));
		info.row      = row_q;
		info.line_end = col_end && plane_end;
		info.img_end  = col_end && plane_end && (({1'b0, row_q} + 17'd1) >= cfg.rows);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			plane_q <= '0;
			row_q   <= '0;
		end else if (advance) begin
			if (col_end) begin
				col_q <= '0;
				if (plane_end) begin
					plane_q <= '0;
					row_q   <= info.img_end ? '0 : row_q + ROW_W'(1);
				end else begin
					plane_q <= plane_q + PLANE_W'(1);
				end
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

endmodule

// ===== rtl/pcx_rle_line_decoder_core.sv =====
// Top level of the PCX run-length line decoder.
//
// Channels: byte_in carries the compressed stream one byte per request;
// pixel_out carries decoded bytes tagged with interleaved destination index,
// row, and last-of-run / last-of-line / last-of-image flags. Both use
// valid/ready; a request moves when both are high.
// Geometry (bytes per plane line, plane count, image rows) is set over the
// APB port at byte addresses 0, 4 and 8; the user must write it only while
// the decoder is idle, which the block itself does not enforce. A literal
// byte passes via the value register and run counter to the output register
// before it appears at pixel_out. A marker byte gives no output; a run,
// clipped at line end, is issued one output byte per cycle through the
// shared position unit while the receiver is not stalling, with the input
// held off until the run's last byte is issued. A stalled receiver freezes
// the output register and the run counter; no byte is lost or repeated.
// Reset clears all positions to row 0, column 0, plane 0 and the geometry
// registers to 1. After the last byte of the image the row count wraps to 0.
module pcx_rle_line_decoder_core
	import pcxrle_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	pcxrle_in_if.sink         byte_in,
	pcxrle_out_if.source      pixel_out,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	cfg_t              cfg;
	pos_info_t         info;

	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  pend_q;
	logic              awaiting_q;
	logic [BYTE_W-1:0] val_q;
	logic              ov_q;

	logic [BYTE_W-1:0] pix_q;
	logic [DEST_W-1:0] dest_q;
	logic [ROW_W-1:0]  row_q;
	logic              run_last_q;
	logic              line_last_q;
	logic              image_last_q;

	logic              emit;
	logic              cur_last;
	logic              last_emit;
	logic              in_ready;
	logic              in_fire;
	logic              is_tag;

	pcxrle_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pcxrle_pos u_pos (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.advance (emit),
		.info    (info)
	);

	assign emit      = (cnt_q != '0) && (!ov_q || pixel_out.ready);
	assign cur_last  = (cnt_q == CNT_W'(1)) || info.line_end;
	assign last_emit = emit && cur_last;
	// next byte may enter in the same cycle the run's final byte is issued
	assign in_ready  = (cnt_q == '0) || last_emit;
	assign in_fire   = byte_in.valid && in_ready;
	assign is_tag    = ((byte_in.in_byte & RUN_TAG) == RUN_TAG);

	assign byte_in.ready        = in_ready;
	assign pixel_out.valid      = ov_q;
	assign pixel_out.pixel_byte = pix_q;
	assign pixel_out.dest_index = dest_q;
	assign pixel_out.row_index  = row_q;
	assign pixel_out.run_last   = run_last_q;
	assign pixel_out.line_last  = line_last_q;
	assign pixel_out.image_last = image_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			pend_q     <= '0;
			awaiting_q <= 1'b0;
			ov_q       <= 1'b0;
		end else begin
			if (emit)
				ov_q <= 1'b1;
			else if (pixel_out.ready)
				ov_q <= 1'b0;

			if (in_fire) begin
				if (awaiting_q) begin
					cnt_q      <= pend_q;
					pend_q     <= '0;
					awaiting_q <= 1'b0;
				end else if (is_tag) begin
					cnt_q      <= '0;
					pend_q     <= CNT_W'(byte_in.in_byte & RUN_COUNT_MASK);
					awaiting_q <= 1'b1;
				end else begin
					cnt_q <= CNT_W'(1);
				end
			end else if (emit) begin
				cnt_q <= info.line_end ? '0 : cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire)
			val_q <= byte_in.in_byte;
		if (emit) begin
			pix_q        <= val_q;
			dest_q       <= info.dest;
			row_q        <= info.row;
			run_last_q   <= cur_last;
			line_last_q  <= info.line_end;
			image_last_q <= info.img_end;
		end
	end

	a_marker_arms: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && !awaiting_q && is_tag |=> awaiting_q && cnt_q == '0)
		else $error("marker byte did not arm value wait");

	a_line_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && line_last_q |-> run_last_q)
		else $error("line end without run end");

	a_image_on_line: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && image_last_q |-> line_last_q)
		else $error("image end off line end");

	a_busy_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != '0) && !last_emit |-> !byte_in.ready)
		else $error("input taken mid-run");

	a_line_clears_run: assert property (@(posedge clk) disable iff (!arst_n)
		emit && info.line_end && !in_fire |=> cnt_q == '0)
		else $error("run continued past line end");

endmodule
